// ===== hw/rtl/drrp_pkg.sv =====
`timescale 1ns / 1ps

package drrp_pkg;

	localparam logic [2:0] PH_IDLE     = 3'd0;
	localparam logic [2:0] PH_NAME_LEN = 3'd1;
	localparam logic [2:0] PH_LABEL    = 3'd2;
	localparam logic [2:0] PH_PTR2     = 3'd3;
	localparam logic [2:0] PH_HEADER   = 3'd4;
	localparam logic [2:0] PH_RDATA    = 3'd5;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_RDATA  = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_RDATA_LEN = 2'd1;
	localparam logic [1:0] ERR_NAME_LEN  = 2'd2;

	localparam logic [7:0] NAME_MAX      = 8'd255;
	localparam logic [3:0] HDR_LAST_IDX  = 4'd9;
	localparam logic [3:0] HDR_SHIFT_END = 4'd8;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] rtype;
		logic [15:0] rclass;
		logic [31:0] ttl;
		logic [15:0] rdlength;
		logic [7:0]  name_length;
		logic        pointer_name;
		logic [7:0]  rdata_byte;
		logic        last;
		logic [1:0]  error_code;
	} result_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} q_status_t;

endpackage

// ===== hw/rtl/dns_resource_record_parser.sv =====
`timescale 1ns / 1ps

// DNS resource record parser.
// Input channel (in_valid/in_ready): one wire byte per beat, with first set on
// the first byte of a record and buffer_len sampled on that beat. Bytes seen
// while no record is open and first is low are dropped.
// Output channel (out_valid/out_ready): one beat per result: a header result
// after the rdlength bytes, one beat per rdata byte with last on the final one,
// or an error beat (rdata longer than the buffer, or owner name past 255 bytes).
// Throughput: one input beat per cycle while the result queue is not full;
// each byte yields at most one result.
// Path: a result is written into a two-entry result queue at the edge that
// accepts its beat, and from there into an output register that drives the output.
// Stall: when out_ready is low the output register holds; the queue absorbs
// two more results, then in_ready drops until the receiver takes a beat.
// Reset: arst_n clears the parser to idle and empties the queue and output
// register; the first record after reset must start with first set.
module dns_resource_record_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        first,
	input  logic [15:0] buffer_len,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [15:0] rtype,
	output logic [15:0] rclass,
	output logic [31:0] ttl,
	output logic [15:0] rdlength,
	output logic [7:0]  name_length,
	output logic        pointer_name,
	output logic [7:0]  rdata_byte,
	output logic        last,
	output logic [1:0]  error_code
);

	drrp_pkg::q_status_t q_status;
	drrp_pkg::result_t   push_data;
	drrp_pkg::result_t   q_data;
	drrp_pkg::result_t   out_data;
	logic                push;
	logic                pop;

	drrp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.first      (first),
		.buffer_len (buffer_len),
		.q_status   (q_status),
		.push       (push),
		.push_data  (push_data)
	);

	drrp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (q_data),
		.status    (q_status)
	);

	drrp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.q_data    (q_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign kind         = out_data.kind;
	assign rtype        = out_data.rtype;
	assign rclass       = out_data.rclass;
	assign ttl          = out_data.ttl;
	assign rdlength     = out_data.rdlength;
	assign name_length  = out_data.name_length;
	assign pointer_name = out_data.pointer_name;
	assign rdata_byte   = out_data.rdata_byte;
	assign last         = out_data.last;
	assign error_code   = out_data.error_code;

endmodule

// ===== hw/rtl/drrp_front.sv =====
`timescale 1ns / 1ps

module drrp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          data_byte,
	input  logic                first,
	input  logic [15:0]         buffer_len,
	input  drrp_pkg::q_status_t q_status,
	output logic                push,
	output drrp_pkg::result_t   push_data
);

	logic [2:0]  phase_q, phase_d, ph;
	logic [5:0]  label_left_q, label_left_d, ll;
	logic [7:0]  name_count_q, name_count_d, nc;
	logic [3:0]  header_index_q, header_index_d, hi;
	logic [63:0] header_shift_q, header_shift_d, hs;
	logic [15:0] bytes_left_q, bytes_left_d, bl, bl_dec;
	logic [15:0] rdata_left_q, rdata_left_d, rl;
	logic        pointer_seen_q, pointer_seen_d, ps;
	logic        has_res;
	logic        accept;

	assign in_ready = !q_status.full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && has_res;

	always_comb begin
		ph     = first ? drrp_pkg::PH_NAME_LEN : phase_q;
		ll     = first ? 6'd0 : label_left_q;
		nc     = first ? 8'd0 : name_count_q;
		hi     = first ? 4'd0 : header_index_q;
		hs     = first ? 64'd0 : header_shift_q;
		bl     = first ? buffer_len : bytes_left_q;
		rl     = first ? 16'd0 : rdata_left_q;
		ps     = first ? 1'b0 : pointer_seen_q;
		bl_dec = (bl != 16'd0) ? bl - 16'd1 : bl;

		phase_d        = ph;
		label_left_d   = ll;
		name_count_d   = nc;
		header_index_d = hi;
		header_shift_d = hs;
		bytes_left_d   = (ph != drrp_pkg::PH_IDLE) ? bl_dec : bl;
		rdata_left_d   = rl;
		pointer_seen_d = ps;
		has_res        = 1'b0;
		push_data      = '0;

		unique case (ph) inside
			drrp_pkg::PH_IDLE: begin
			end
			drrp_pkg::PH_NAME_LEN, drrp_pkg::PH_LABEL, drrp_pkg::PH_PTR2: begin
				if (nc == drrp_pkg::NAME_MAX) begin
					has_res              = 1'b1;
					push_data.kind       = drrp_pkg::KIND_ERROR;
					push_data.last       = 1'b1;
					push_data.error_code = drrp_pkg::ERR_NAME_LEN;
					phase_d              = drrp_pkg::PH_IDLE;
				end else begin
					name_count_d = nc + 8'd1;
					if (ph == drrp_pkg::PH_NAME_LEN) begin
						if (data_byte == 8'd0) begin
							phase_d = drrp_pkg::PH_HEADER;
						end else if (data_byte[7:6] == 2'b11) begin
							pointer_seen_d = 1'b1;
							phase_d        = drrp_pkg::PH_PTR2;
						end else if (data_byte[5:0] != 6'd0) begin
							label_left_d = data_byte[5:0];
							phase_d      = drrp_pkg::PH_LABEL;
						end
					end else if (ph == drrp_pkg::PH_LABEL) begin
						label_left_d = ll - 6'd1;
						if (ll == 6'd1) begin
							phase_d = drrp_pkg::PH_NAME_LEN;
						end
					end else begin
						phase_d = drrp_pkg::PH_HEADER;
					end
					if (phase_d == drrp_pkg::PH_HEADER) begin
						header_index_d = 4'd0;
						header_shift_d = 64'd0;
						rdata_left_d   = 16'd0;
					end
				end
			end
			drrp_pkg::PH_HEADER: begin
				if (hi < drrp_pkg::HDR_SHIFT_END) begin
					header_shift_d = {hs[55:0], data_byte};
				end else begin
					rdata_left_d = {rl[7:0], data_byte};
				end
				header_index_d = hi + 4'd1;
				if (hi == drrp_pkg::HDR_LAST_IDX) begin
					has_res                = 1'b1;
					push_data.rtype        = header_shift_d[63:48];
					push_data.rclass       = header_shift_d[47:32];
					push_data.ttl          = header_shift_d[31:0];
					push_data.rdlength     = rdata_left_d;
					push_data.name_length  = nc;
					push_data.pointer_name = ps;
					if (rdata_left_d > bl_dec) begin
						push_data.kind       = drrp_pkg::KIND_ERROR;
						push_data.last       = 1'b1;
						push_data.error_code = drrp_pkg::ERR_RDATA_LEN;
						phase_d              = drrp_pkg::PH_IDLE;
					end else begin
						push_data.kind = drrp_pkg::KIND_HEADER;
						push_data.last = (rdata_left_d == 16'd0);
						phase_d        = (rdata_left_d == 16'd0) ?
							drrp_pkg::PH_IDLE : drrp_pkg::PH_RDATA;
					end
				end
			end
			drrp_pkg::PH_RDATA: begin
				rdata_left_d         = rl - 16'd1;
				has_res              = 1'b1;
				push_data.kind       = drrp_pkg::KIND_RDATA;
				push_data.rdata_byte = data_byte;
				push_data.last       = (rl == 16'd1);
				if (rl == 16'd1) begin
					phase_d = drrp_pkg::PH_IDLE;
				end
			end
			default: begin
				phase_d = drrp_pkg::PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= drrp_pkg::PH_IDLE;
			label_left_q   <= '0;
			name_count_q   <= '0;
			header_index_q <= '0;
			header_shift_q <= '0;
			bytes_left_q   <= '0;
			rdata_left_q   <= '0;
			pointer_seen_q <= 1'b0;
		end else if (accept) begin
			phase_q        <= phase_d;
			label_left_q   <= label_left_d;
			name_count_q   <= name_count_d;
			header_index_q <= header_index_d;
			header_shift_q <= header_shift_d;
			bytes_left_q   <= bytes_left_d;
			rdata_left_q   <= rdata_left_d;
			pointer_seen_q <= pointer_seen_d;
		end
	end

endmodule

// ===== hw/rtl/drrp_queue.sv =====
`timescale 1ns / 1ps

module drrp_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  drrp_pkg::result_t   push_data,
	input  logic                pop,
	output drrp_pkg::result_t   pop_data,
	output drrp_pkg::q_status_t status
);

	drrp_pkg::result_t mem_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;

	assign status.full      = (count_q == 2'd2);
	assign status.not_empty = (count_q != 2'd0);
	assign pop_data         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/drrp_back.sv =====
`timescale 1ns / 1ps

module drrp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  drrp_pkg::q_status_t q_status,
	input  drrp_pkg::result_t   q_data,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output drrp_pkg::result_t   out_data
);

	logic              valid_q;
	drrp_pkg::result_t data_q;

	assign pop       = q_status.not_empty && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || out_ready) begin
			valid_q <= q_status.not_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= q_data;
		end
	end

endmodule
